// ----- sv/bad_pkg.sv -----
// Shared types, codes and constants for the box average downscaler.
// Used by bad_ctrl, bad_datapath, box_average_downscaler and the testbench.
package bad_pkg;

  localparam int DIM_W = 13;
  localparam int CH_W = 8;
  localparam int FMT_W = 2;
  localparam int ST_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int AREA_W = 2 * DIM_W;
  localparam int SUM_W = AREA_W + CH_W;

  localparam int DEF_MAX_EDGE = 512;
  localparam int MAX_DIM = 4096;
  localparam logic [DIM_W-1:0] RESET_MAX_EDGE = 13'd512;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd3;

  localparam logic [FMT_W-1:0] FMT_RGBA = 2'd0;
  localparam logic [FMT_W-1:0] FMT_BGRA = 2'd1;
  localparam logic [FMT_W-1:0] FMT_GRAY = 2'd2;
  localparam logic [FMT_W-1:0] FMT_BAD = 2'd3;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_ARG = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_FMT = 2'd2;

  typedef enum logic [2:0] {
    DIV_BS,
    DIV_COLS,
    DIV_ROWS,
    DIV_R,
    DIV_G,
    DIV_B
  } div_op_t;

  typedef struct packed {
    logic      latch_in;
    logic      frame_init;
    logic      frame_err;
    logic      div_start;
    logic      div_capture;
    div_op_t   div_op;
    logic      set_area;
    logic      mem_read;
    logic      mem_write;
    logic      advance;
    logic      load_ok;
    logic      load_err;
  } cmd_t;

  typedef struct packed {
    logic            frame_start;
    logic [ST_W-1:0] cfg_status;
    logic            in_frame;
    logic            hit;
    logic            emit;
    logic            div_done;
    logic            out_free;
  } sts_t;

endpackage

// ----- sv/bad_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Uses no package items; shared by all divisions of the downscaler datapath.
module bad_div #(
  parameter int NumW = 34,
  parameter int DenW = 26
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] dividend,
  input  logic [DenW-1:0] divisor,
  output logic            done,
  output logic [NumW-1:0] quotient
);

  localparam int CNT_W = $clog2(NumW + 1);

  logic [DenW-1:0]  rem;
  logic [NumW-1:0]  quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DenW:0]    shifted;
  logic             fits;

  assign shifted = {rem, quo[NumW-1]};
  assign fits = shifted >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DenW'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[DenW-1:0];
      end
      quo <= {quo[NumW-2:0], fits};
    end
  end

endmodule

// ----- sv/bad_ctrl.sv -----
// Sequencer of the downscaler: one item at a time through check, setup divisions,
// line store update, average divisions and output. Depends on bad_pkg.
module bad_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bad_pkg::sts_t sts,
  output bad_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE, CHECK, DIVGO, DIVW, AREA, RD, ACC, EMIT, ADV, ERR
  } state_t;

  state_t           state, state_next;
  bad_pkg::div_op_t op, op_next;

  assign in_stall = state != IDLE;

  always_comb begin
    state_next = state;
    op_next = op;
    cmd = '0;
    cmd.div_op = op;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (sts.frame_start) begin
          if (sts.cfg_status != bad_pkg::ST_OK) begin
            cmd.frame_err = 1'b1;
            state_next = ERR;
          end else begin
            cmd.frame_init = 1'b1;
            op_next = bad_pkg::DIV_BS;
            state_next = DIVGO;
          end
        end else if (sts.in_frame) begin
          state_next = RD;
        end else begin
          state_next = IDLE;
        end
      end
      DIVGO: begin
        cmd.div_start = 1'b1;
        state_next = DIVW;
      end
      DIVW: begin
        if (sts.div_done) begin
          cmd.div_capture = 1'b1;
          case (op)
            bad_pkg::DIV_BS: begin
              op_next = bad_pkg::DIV_COLS;
              state_next = DIVGO;
            end
            bad_pkg::DIV_COLS: begin
              op_next = bad_pkg::DIV_ROWS;
              state_next = DIVGO;
            end
            bad_pkg::DIV_ROWS: state_next = AREA;
            bad_pkg::DIV_R: begin
              op_next = bad_pkg::DIV_G;
              state_next = DIVGO;
            end
            bad_pkg::DIV_G: begin
              op_next = bad_pkg::DIV_B;
              state_next = DIVGO;
            end
            default: state_next = EMIT;
          endcase
        end
      end
      AREA: begin
        cmd.set_area = 1'b1;
        state_next = RD;
      end
      RD: begin
        if (sts.hit) begin
          cmd.mem_read = 1'b1;
          state_next = ACC;
        end else begin
          state_next = ADV;
        end
      end
      ACC: begin
        cmd.mem_write = 1'b1;
        if (sts.emit) begin
          op_next = bad_pkg::DIV_R;
          state_next = DIVGO;
        end else begin
          state_next = ADV;
        end
      end
      EMIT: begin
        if (sts.out_free) begin
          cmd.load_ok = 1'b1;
          state_next = ADV;
        end
      end
      ADV: begin
        cmd.advance = 1'b1;
        state_next = IDLE;
      end
      ERR: begin
        if (sts.out_free) begin
          cmd.load_err = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      op <= bad_pkg::DIV_BS;
    end else begin
      state <= state_next;
      op <= op_next;
    end
  end

endmodule

// ----- sv/bad_datapath.sv -----
// Datapath: config registers, frame setup, position counters, column-sum line store
// and output register. Depends on bad_pkg and bad_div.
module bad_datapath #(
  parameter int MaxEdge = bad_pkg::DEF_MAX_EDGE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bad_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            frame_start,
  input  logic [bad_pkg::CH_W-1:0]        chan_a,
  input  logic [bad_pkg::CH_W-1:0]        chan_b,
  input  logic [bad_pkg::CH_W-1:0]        chan_c,
  input  bad_pkg::cmd_t                   cmd,
  output bad_pkg::sts_t                   sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bad_pkg::CH_W-1:0]        red,
  output logic [bad_pkg::CH_W-1:0]        green,
  output logic [bad_pkg::CH_W-1:0]        blue,
  output logic [bad_pkg::ST_W-1:0]        status,
  output logic                            last,
  output logic [bad_pkg::DIM_W-1:0]       preview_width,
  output logic [bad_pkg::DIM_W-1:0]       preview_height
);

  localparam int DW = bad_pkg::DIM_W;
  localparam int CW = bad_pkg::CH_W;
  localparam int SW = bad_pkg::SUM_W;
  localparam int AW2 = bad_pkg::AREA_W;
  localparam int AW = (MaxEdge > 1) ? $clog2(MaxEdge) : 1;

  // configuration
  logic [DW-1:0]              cfg_w, cfg_h, cfg_me;
  logic [bad_pkg::FMT_W-1:0]  cfg_fmt;

  // latched request
  logic          req_fs;
  logic [CW-1:0] req_a, req_b, req_c;

  // frame setup
  logic [DW-1:0]             lat_w, lat_h, bs, cols, rows, span_w, span_h;
  logic [bad_pkg::FMT_W-1:0] lat_fmt;
  logic [AW2-1:0]            area;
  logic                      in_frame;

  // position
  logic [DW-1:0] px, py, dx, dy, col, row;

  // line store
  logic [SW-1:0] mem_r [MaxEdge];
  logic [SW-1:0] mem_g [MaxEdge];
  logic [SW-1:0] mem_b [MaxEdge];
  logic [SW-1:0] rd_r, rd_g, rd_b, sum_r, sum_g, sum_b;
  logic [SW-1:0] new_r, new_g, new_b;
  logic [CW-1:0] pr, pg, pb, avg_r, avg_g;
  logic [AW-1:0] addr;
  logic          first;

  logic [DW-1:0]         longest;
  logic [DW:0]           bs_num;
  logic [SW-1:0]         div_num, div_q;
  logic [AW2-1:0]        div_den;
  logic                  div_done;
  logic [bad_pkg::ST_W-1:0] cfg_st;
  logic [DW:0]           px_inc, py_inc, dx_inc, dy_inc;
  logic [DW-1:0]         q_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= '0;
      cfg_h <= '0;
      cfg_me <= bad_pkg::RESET_MAX_EDGE;
      cfg_fmt <= bad_pkg::FMT_RGBA;
    end else if (cfg_we) begin
      case (cfg_index)
        bad_pkg::REG_FRAME_WIDTH:  cfg_w <= cfg_data;
        bad_pkg::REG_FRAME_HEIGHT: cfg_h <= cfg_data;
        bad_pkg::REG_MAX_EDGE:     cfg_me <= cfg_data;
        bad_pkg::REG_PIXEL_FORMAT: cfg_fmt <= cfg_data[bad_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_me == '0 || cfg_me > DW'(MaxEdge)) begin
      cfg_st = bad_pkg::ST_BAD_ARG;
    end else if (cfg_fmt == bad_pkg::FMT_BAD) begin
      cfg_st = bad_pkg::ST_BAD_FMT;
    end else if (cfg_w == '0 || cfg_h == '0 || cfg_w > DW'(bad_pkg::MAX_DIM) ||
                 cfg_h > DW'(bad_pkg::MAX_DIM)) begin
      cfg_st = bad_pkg::ST_BAD_ARG;
    end else begin
      cfg_st = bad_pkg::ST_OK;
    end
  end

  assign longest = (cfg_w > cfg_h) ? cfg_w : cfg_h;
  assign bs_num = {1'b0, longest} + {1'b0, cfg_me} - 1'b1;

  // channel order
  always_comb begin
    case (lat_fmt)
      bad_pkg::FMT_GRAY: begin
        pr = req_a;
        pg = req_a;
        pb = req_a;
      end
      bad_pkg::FMT_BGRA: begin
        pr = req_c;
        pg = req_b;
        pb = req_a;
      end
      default: begin
        pr = req_a;
        pg = req_b;
        pb = req_c;
      end
    endcase
  end

  always_comb begin
    case (cmd.div_op)
      bad_pkg::DIV_BS: begin
        div_num = SW'(bs_num);
        div_den = AW2'(cfg_me);
      end
      bad_pkg::DIV_COLS: begin
        div_num = SW'(lat_w);
        div_den = AW2'(bs);
      end
      bad_pkg::DIV_ROWS: begin
        div_num = SW'(lat_h);
        div_den = AW2'(bs);
      end
      bad_pkg::DIV_R: begin
        div_num = sum_r;
        div_den = area;
      end
      bad_pkg::DIV_G: begin
        div_num = sum_g;
        div_den = area;
      end
      default: begin
        div_num = sum_b;
        div_den = area;
      end
    endcase
  end

  bad_div #(
    .NumW(SW),
    .DenW(AW2)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .dividend(div_num),
    .divisor(div_den),
    .done(div_done),
    .quotient(div_q)
  );

  // clamp preview dimensions to at least one
  assign q_dim = (div_q == '0) ? DW'(1) : div_q[DW-1:0];

  assign addr = col[AW-1:0];
  assign first = dx == '0 && dy == '0;
  assign new_r = first ? SW'(pr) : rd_r + SW'(pr);
  assign new_g = first ? SW'(pg) : rd_g + SW'(pg);
  assign new_b = first ? SW'(pb) : rd_b + SW'(pb);

  assign px_inc = {1'b0, px} + 1'b1;
  assign py_inc = {1'b0, py} + 1'b1;
  assign dx_inc = {1'b0, dx} + 1'b1;
  assign dy_inc = {1'b0, dy} + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_fs <= frame_start;
      req_a <= chan_a;
      req_b <= chan_b;
      req_c <= chan_c;
    end
    if (cmd.frame_init) begin
      lat_w <= cfg_w;
      lat_h <= cfg_h;
      lat_fmt <= cfg_fmt;
    end
    if (cmd.div_capture) begin
      case (cmd.div_op)
        bad_pkg::DIV_BS:   bs <= div_q[DW-1:0];
        bad_pkg::DIV_COLS: cols <= q_dim;
        bad_pkg::DIV_ROWS: rows <= q_dim;
        bad_pkg::DIV_R:    avg_r <= div_q[CW-1:0];
        bad_pkg::DIV_G:    avg_g <= div_q[CW-1:0];
        default: ;
      endcase
    end
    if (cmd.set_area) begin
      span_w <= (lat_w < bs) ? lat_w : bs;
      span_h <= (lat_h < bs) ? lat_h : bs;
      area <= AW2'((lat_w < bs) ? lat_w : bs) * AW2'((lat_h < bs) ? lat_h : bs);
    end
    if (cmd.mem_read) begin
      rd_r <= mem_r[addr];
      rd_g <= mem_g[addr];
      rd_b <= mem_b[addr];
    end
    if (cmd.mem_write) begin
      mem_r[addr] <= new_r;
      mem_g[addr] <= new_g;
      mem_b[addr] <= new_b;
      sum_r <= new_r;
      sum_g <= new_g;
      sum_b <= new_b;
    end
  end

  // position counters and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      px <= '0;
      py <= '0;
      dx <= '0;
      dy <= '0;
      col <= '0;
      row <= '0;
    end else if (cmd.frame_err) begin
      in_frame <= 1'b0;
    end else if (cmd.frame_init) begin
      in_frame <= 1'b1;
      px <= '0;
      py <= '0;
      dx <= '0;
      dy <= '0;
      col <= '0;
      row <= '0;
    end else if (cmd.advance) begin
      if (px_inc >= {1'b0, lat_w}) begin
        px <= '0;
        dx <= '0;
        col <= '0;
        if (py_inc >= {1'b0, lat_h}) begin
          py <= '0;
          dy <= '0;
          row <= '0;
          in_frame <= 1'b0;
        end else begin
          py <= py_inc[DW-1:0];
          if (dy_inc == {1'b0, bs}) begin
            dy <= '0;
            row <= row + 1'b1;
          end else begin
            dy <= dy_inc[DW-1:0];
          end
        end
      end else begin
        px <= px_inc[DW-1:0];
        if (dx_inc == {1'b0, bs}) begin
          dx <= '0;
          col <= col + 1'b1;
        end else begin
          dx <= dx_inc[DW-1:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_ok || cmd.load_err) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ok) begin
      red <= avg_r;
      green <= avg_g;
      blue <= div_q[CW-1:0];
      status <= bad_pkg::ST_OK;
      last <= (DW'(col + 1'b1) == cols) && (DW'(row + 1'b1) == rows);
      preview_width <= cols;
      preview_height <= rows;
    end else if (cmd.load_err) begin
      red <= '0;
      green <= '0;
      blue <= '0;
      status <= cfg_st;
      last <= 1'b1;
      preview_width <= '0;
      preview_height <= '0;
    end
  end

  // blue quotient stays held in the divider until the next start
  always_comb begin
    sts.frame_start = req_fs;
    sts.cfg_status = cfg_st;
    sts.in_frame = in_frame;
    sts.hit = in_frame && col < cols && row < rows && col < DW'(MaxEdge);
    sts.emit = (DW'(dx + 1'b1) == span_w) && (DW'(dy + 1'b1) == span_h);
    sts.div_done = div_done;
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

// ----- sv/box_average_downscaler.sv -----
// Top level of the box average downscaler: controller plus datapath.
// Depends on bad_pkg, bad_ctrl, bad_datapath (and bad_div below it).
//
// Usage: source pixels enter in raster order on the input channel (in_valid /
// in_stall), frame_start marking the first pixel of each frame. Registers are
// written through cfg_we / cfg_index / cfg_data while the block is idle; the
// values seen at frame_start govern that frame. Preview pixels leave on the
// output channel (out_valid / out_stall), one per completed block.
// One request at a time; in_stall is high until the sequencer is idle.
//   A pixel outside any frame is only checked, one in a dropped edge block is
//   also skipped, one inside a block also updates the line store, and one
//   closing a block runs three average divisions on the shared divider
//   (one bit per cycle, SUM_W = 34). frame_start adds three setup divisions.
// A bad configuration gives one error result on the frame_start pixel and the
// rest of the frame is ignored.
// Reset clears control state and loads the register defaults; no clearing pass
// is needed. A result waits in the output register while out_stall is high; the
// block keeps taking pixels until it needs the output register again.
module box_average_downscaler #(
  parameter int MAX_EDGE = bad_pkg::DEF_MAX_EDGE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bad_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            frame_start,
  input  logic [bad_pkg::CH_W-1:0]        chan_a,
  input  logic [bad_pkg::CH_W-1:0]        chan_b,
  input  logic [bad_pkg::CH_W-1:0]        chan_c,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bad_pkg::CH_W-1:0]        red,
  output logic [bad_pkg::CH_W-1:0]        green,
  output logic [bad_pkg::CH_W-1:0]        blue,
  output logic [bad_pkg::ST_W-1:0]        status,
  output logic                            last,
  output logic [bad_pkg::DIM_W-1:0]       preview_width,
  output logic [bad_pkg::DIM_W-1:0]       preview_height
);

  bad_pkg::cmd_t cmd;
  bad_pkg::sts_t sts;

  bad_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts(sts),
    .cmd(cmd)
  );

  bad_datapath #(
    .MaxEdge(MAX_EDGE)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .frame_start(frame_start),
    .chan_a(chan_a),
    .chan_b(chan_b),
    .chan_c(chan_c),
    .cmd(cmd),
    .sts(sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .status(status),
    .last(last),
    .preview_width(preview_width),
    .preview_height(preview_height)
  );

endmodule

// ----- test/tb_preview_checker.sv -----
// Checker for the box average downscaler: watches the register port and both
// request channels, predicts each preview pixel and compares it. Needs bad_pkg.
module tb_preview_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bad_pkg::DIM_W-1:0]   cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        frame_start,
  input  logic [7:0]                  chan_a,
  input  logic [7:0]                  chan_b,
  input  logic [7:0]                  chan_c,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  input  logic [1:0]                  status,
  input  logic                        last,
  input  logic [12:0]                 preview_width,
  input  logic [12:0]                 preview_height,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bad_pkg::*;

  localparam int LINE_LEN = 512;

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [1:0]  st;
    logic        lst;
    logic [12:0] pw;
    logic [12:0] ph;
  } preview_px_t;

  preview_px_t preview_q[$];

  logic [12:0] reg_w, reg_h, reg_edge;
  logic [1:0]  reg_fmt;
  longint      line_r[LINE_LEN], line_g[LINE_LEN], line_b[LINE_LEN];
  int          pos_x, pos_y, blk, cols, rows, span_x, span_y, lat_w, lat_h;
  longint      area;
  logic [1:0]  lat_fmt;
  bit          active, dropping;

  function automatic logic [1:0] open_frame();
    int longest;
    if (reg_edge == 0 || reg_edge > LINE_LEN) return ST_BAD_ARG;
    if (reg_fmt == FMT_BAD) return ST_BAD_FMT;
    if (reg_w == 0 || reg_h == 0 || reg_w > MAX_DIM || reg_h > MAX_DIM) return ST_BAD_ARG;
    longest = (reg_w > reg_h) ? reg_w : reg_h;
    blk = (longest + reg_edge - 1) / reg_edge;
    if (blk == 0) blk = 1;
    cols = reg_w / blk;
    if (cols == 0) cols = 1;
    rows = reg_h / blk;
    if (rows == 0) rows = 1;
    span_x = (reg_w < blk) ? reg_w : blk;
    span_y = (reg_h < blk) ? reg_h : blk;
    area = longint'(span_x) * span_y;
    lat_w = reg_w;
    lat_h = reg_h;
    lat_fmt = reg_fmt;
    pos_x = 0;
    pos_y = 0;
    return ST_OK;
  endfunction

  task automatic take_pixel(logic fs, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [1:0]  st;
    logic [7:0]  r, g, bl;
    int          col, row, dx, dy;
    preview_px_t px;
    if (fs) begin
      st = open_frame();
      if (st != ST_OK) begin
        dropping = 1;
        active = 0;
        px = '{r: '0, g: '0, b: '0, st: st, lst: 1'b1, pw: '0, ph: '0};
        preview_q.push_back(px);
        return;
      end
      dropping = 0;
      active = 1;
    end
    if (!active || dropping) return;
    case (lat_fmt)
      FMT_GRAY: begin r = a; g = a; bl = a; end
      FMT_BGRA: begin r = c; g = b; bl = a; end
      default:  begin r = a; g = b; bl = c; end
    endcase
    col = pos_x / blk;
    row = pos_y / blk;
    dx = pos_x % blk;
    dy = pos_y % blk;
    if (col < cols && row < rows && col < LINE_LEN) begin
      if (dx == 0 && dy == 0) begin
        line_r[col] = r;
        line_g[col] = g;
        line_b[col] = bl;
      end else begin
        line_r[col] += r;
        line_g[col] += g;
        line_b[col] += bl;
      end
      if (dx + 1 == span_x && dy + 1 == span_y) begin
        px.r = 8'(line_r[col] / area);
        px.g = 8'(line_g[col] / area);
        px.b = 8'(line_b[col] / area);
        px.st = ST_OK;
        px.lst = (col + 1 == cols && row + 1 == rows);
        px.pw = 13'(cols);
        px.ph = 13'(rows);
        preview_q.push_back(px);
      end
    end
    pos_x++;
    if (pos_x >= lat_w) begin
      pos_x = 0;
      pos_y++;
      if (pos_y >= lat_h) begin
        pos_y = 0;
        active = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    preview_px_t got, want;
    if (rst) begin
      reg_w = '0; reg_h = '0; reg_edge = RESET_MAX_EDGE; reg_fmt = FMT_RGBA;
      pos_x = 0; pos_y = 0; blk = 1; cols = 1; rows = 1; area = 1;
      span_x = 0; span_y = 0; lat_w = 0; lat_h = 0; lat_fmt = FMT_RGBA;
      active = 0; dropping = 0;
      preview_q.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall) take_pixel(frame_start, chan_a, chan_b, chan_c);
      if (out_valid && !out_stall) begin
        got = '{r: red, g: green, b: blue, st: status, lst: last,
                pw: preview_width, ph: preview_height};
        if (preview_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected preview pixel %p", $realtime, got);
        end else begin
          want = preview_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  reg_w = cfg_data;
          REG_FRAME_HEIGHT: reg_h = cfg_data;
          REG_MAX_EDGE:     reg_edge = cfg_data;
          REG_PIXEL_FORMAT: reg_fmt = cfg_data[1:0];
          default: ;
        endcase
      end
    end
    pending = preview_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Top of the downscaler testbench: clock, reset, register writes, pixel and
// preview traffic, watchdog and verdict. Needs bad_pkg, the block and the checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bad_pkg::*;

  localparam int QUIET_CYCLES = 200;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  logic                 clk, rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 in_valid, in_stall, frame_start;
  logic [7:0]           chan_a, chan_b, chan_c;
  logic                 out_valid, out_stall;
  logic [7:0]           red, green, blue;
  logic [1:0]           status;
  logic                 last;
  logic [12:0]          preview_width, preview_height;
  int                   errors, pending;
  int                   idle_cycles;
  int                   pixels_sent;
  bit                   no_gaps, hold_req, pressure_done;

  box_average_downscaler dut (.*);

  tb_preview_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stall per request, one long hold-off on demand.
  initial begin
    int g;
    out_stall = 1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      g = no_gaps ? 0 : $urandom_range(0, 10);
      if (g > 0) begin
        out_stall <= 1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic wait_quiet();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int me, int fmt);
    wait_quiet();
    cfg_we <= 1; cfg_index <= REG_FRAME_WIDTH; cfg_data <= DIM_W'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT; cfg_data <= DIM_W'(h);
    @(posedge clk);
    cfg_index <= REG_MAX_EDGE; cfg_data <= DIM_W'(me);
    @(posedge clk);
    cfg_index <= REG_PIXEL_FORMAT; cfg_data <= DIM_W'(fmt);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Offer one pixel request and hold it until accepted.
  task automatic send_pixel(bit fs, int fill);
    int g;
    g = no_gaps ? 0 : $urandom_range(0, 10);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    frame_start <= fs;
    chan_a <= 8'((fill < 0) ? $urandom_range(0, 255) : fill);
    chan_b <= 8'((fill < 0) ? $urandom_range(0, 255) : fill);
    chan_c <= 8'((fill < 0) ? $urandom_range(0, 255) : fill);
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic send_frame(int npix, int fill);
    for (int i = 0; i < npix; i++) send_pixel(i == 0, fill);
  endtask

  initial begin
    int w, h, me, fmt, npix, pick;
    rst = 1; cfg_we = 0; cfg_index = REG_FRAME_WIDTH; cfg_data = '0;
    in_valid = 0; frame_start = 0; chan_a = 0; chan_b = 0; chan_c = 0;
    no_gaps = 0; hold_req = 0; pressure_done = 0; pixels_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Stray pixel before any frame, then the reset registers (width zero).
    send_pixel(0, -1);
    send_frame(2, -1);
    set_frame(2, 2, 1, FMT_RGBA);
    send_frame(4, 255);
    set_frame(2, 2, 1, FMT_BGRA);
    send_frame(4, 0);
    set_frame(2, 1, 1, FMT_GRAY);   // short side below the block
    send_frame(2, -1);
    set_frame(1, 3, 1, FMT_BGRA);
    send_frame(3, -1);
    set_frame(4, 4, 0, FMT_RGBA);   // bad max_edge
    send_frame(2, -1);
    set_frame(4, 4, 513, FMT_BAD);  // max_edge checked before format
    send_frame(1, -1);
    set_frame(4, 4, 8191, FMT_RGBA);
    send_frame(1, -1);
    set_frame(4, 4, 2, FMT_BAD);
    send_frame(1, -1);
    set_frame(4097, 8191, 512, FMT_RGBA);
    send_frame(1, -1);
    set_frame(4, 0, 2, FMT_GRAY);
    send_frame(1, -1);
    // Widest frame, abandoned early by a new frame_start.
    set_frame(4096, 4096, 512, FMT_RGBA);
    send_frame(17, -1);
    send_frame(1, -1);
    send_pixel(0, -1);

    while (pixels_sent < 620) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      me = $urandom_range(1, 6);
      fmt = $urandom_range(0, 2);
      pick = $urandom_range(0, 19);
      case (pick)
        0: me = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(513, 8191);
        1: fmt = FMT_BAD;
        2: w = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(4097, 8191);
        default: ;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      // One configuration of back-to-back pixels against a long receiver hold-off.
      if (!pressure_done && pixels_sent > 300) begin
        w = 12; h = 12; me = 6; fmt = FMT_RGBA; no_gaps = 1; hold_req = 1;
        pressure_done = 1;
      end
      set_frame(w, h, me, fmt);
      for (int rep = $urandom_range(1, 2); rep > 0; rep--) begin
        npix = w * h;
        if ($urandom_range(0, 7) == 0) npix = $urandom_range(1, npix);
        send_frame(npix, -1);
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3)) send_pixel(0, -1);
      end
    end

    no_gaps = 0;
    wait_quiet();
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
